// ----- rtl/tcgp_pkg.sv -----
package tcgp_pkg;

  localparam int PosBits = 24;

  typedef enum logic [4:0] {
    PH_HPCR, PH_HTYPE, PH_HDIG, PH_HSIZE, PH_HSIG, PH_HPLAT, PH_HVER, PH_HNALG,
    PH_HALGID, PH_HALGSZ, PH_HVSIZE, PH_HVEND, PH_BOUND, PH_TRAIL, PH_EPCR,
    PH_ETYPE, PH_ECNT, PH_EALG, PH_EDIG, PH_EDSZ, PH_EDATA
  } phase_t;

  typedef enum logic [3:0] {
    ROLE_HDR, ROLE_HALG, ROLE_VEND, ROLE_PCR, ROLE_TYPE, ROLE_DCNT, ROLE_DALG,
    ROLE_DIG, ROLE_DSZ, ROLE_DATA, ROLE_TRAIL, ROLE_AFTER_ERR
  } role_t;

  typedef enum logic [3:0] {
    ERR_NONE, ERR_SHORT, ERR_HPCR, ERR_HTYPE, ERR_HDIG, ERR_SIG, ERR_HALG,
    ERR_ETYPE, ERR_DALG, ERR_TRUNC
  } err_t;

  localparam logic [23:0] MinLogLen = 24'd65;
  localparam logic [7:0] TrailMax = 8'd16;

  typedef struct packed {
    logic [3:0]  role;
    logic [7:0]  byte_value;
    logic [23:0] event_number;
    logic [31:0] pcr_index;
    logic [4:0]  event_type_code;
    logic [2:0]  alg_code;
    logic [31:0] field_value;
    logic        field_done;
    logic        selected;
    logic [3:0]  error;
    logic        log_done;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd0: r = 8'h53;  4'd1: r = 8'h70;  4'd2: r = 8'h65;  4'd3: r = 8'h63;
      4'd4: r = 8'h20;  4'd5: r = 8'h49;  4'd6: r = 8'h44;  4'd7: r = 8'h20;
      4'd8: r = 8'h45;  4'd9: r = 8'h76;  4'd10: r = 8'h65; 4'd11: r = 8'h6e;
      4'd12: r = 8'h74; 4'd13: r = 8'h30; 4'd14: r = 8'h33; default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] hash_alg(input logic [31:0] v);
    logic [3:0] r;
    unique case (v)
      32'h04: r = 4'd0;
      32'h0B: r = 4'd1;
      32'h0C: r = 4'd2;
      32'h0D: r = 4'd3;
      32'h10: r = 4'd4;
      32'h23: r = 4'd5;
      32'h24: r = 4'd6;
      32'h25: r = 4'd7;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] digest_len(input logic [2:0] a);
    logic [6:0] r;
    unique case (a)
      3'd0: r = 7'd20;
      3'd1, 3'd4, 3'd5: r = 7'd32;
      3'd2, 3'd6: r = 7'd48;
      default: r = 7'd64;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] type_code(input logic [31:0] v);
    logic [31:0] d;
    logic [5:0] r;
    d = v - 32'h80000001;
    if (v <= 32'd17) r = {1'b0, v[4:0]};
    else if (v >= 32'h80000001 && v <= 32'h8000000A) r = {1'b0, 5'(d[4:0] + 5'd18)};
    else if (v == 32'h800000E0) r = 6'd28;
    else r = 6'h20;
    return r;
  endfunction

endpackage

// ----- rtl/tcgp_core.sv -----
module tcgp_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             b,
  input  logic                   first,
  input  logic [23:0]            log_length,
  input  logic [31:0]            pcr_mask,
  output tcgp_pkg::result_t      res
);
  import tcgp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  fbc_r, fbc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] items_r, items_nxt;
  logic [31:0] bleft_r, bleft_nxt;
  logic [PosBits-1:0] pos_r, pos_nxt;
  logic [23:0] evc_r, evc_nxt;
  logic [31:0] pcr_r, pcr_nxt;
  logic [4:0]  type_r, type_nxt;
  logic [2:0]  alg_r, alg_nxt;
  logic [3:0]  err_r, err_nxt;

  phase_t      ph0, ph;
  logic [4:0]  fbc0;
  logic [31:0] acc0, accb, pcr0;
  logic [PosBits-1:0] pos0;
  logic [23:0] evc0;
  logic [3:0]  err0;
  logic [1:0]  n;
  logic        fld2, fld4, fd;
  logic [31:0] fv;
  logic [3:0]  role;
  logic        done;
  logic [3:0]  ha;
  logic [5:0]  tc;
  logic [PosBits:0] rem;
  logic        cnt_last;

  always_comb begin
    ph0  = first ? PH_HPCR : phase_r;
    fbc0 = first ? 5'd0 : fbc_r;
    acc0 = first ? 32'd0 : acc_r;
    pos0 = first ? '0 : pos_r;
    evc0 = first ? 24'd0 : evc_r;
    pcr0 = first ? 32'd0 : pcr_r;
    err0 = first ? ERR_NONE : err_r;
    n    = fbc0[1:0];
    accb = acc0 | (32'(b) << {n, 3'b000});
    fld4 = (n == 2'd3);
    fld2 = (n != 2'd0);
    ha   = hash_alg(accb);
    tc   = type_code(accb);
    rem  = (PosBits+1)'(log_length) - {1'b0, pos0};
    done = ({1'b0, pos0} + 1'b1) == (PosBits+1)'(log_length);

    phase_nxt = ph0;  fbc_nxt = fbc0;  acc_nxt = acc0;
    items_nxt = first ? 32'd0 : items_r;
    bleft_nxt = first ? 32'd0 : bleft_r;
    evc_nxt = evc0;  pcr_nxt = pcr0;
    type_nxt = first ? 5'd0 : type_r;
    alg_nxt = first ? 3'd0 : alg_r;
    err_nxt = err0;
    fd = 1'b0; fv = 32'd0; role = ROLE_TRAIL;
    ph = ph0;
    cnt_last = 1'b0;

    if (err0 != ERR_NONE) begin
      role = ROLE_AFTER_ERR;
    end else if (pos0 == '0 && log_length < MinLogLen) begin
      err_nxt = ERR_SHORT;
      role = ROLE_HDR;
    end else if ((PosBits+1)'({1'b0, pos0}) >= (PosBits+1)'(log_length)) begin
      role = ROLE_TRAIL;
    end else begin
      if (ph0 == PH_BOUND) ph = (rem <= (PosBits+1)'(TrailMax)) ? PH_TRAIL : PH_EPCR;
      phase_nxt = ph;
      role = ROLE_HDR;
      // multi-byte field accumulate
      if (ph == PH_HALGID || ph == PH_HALGSZ || ph == PH_EALG) begin
        fd = fld2;
      end else if (ph == PH_HPCR || ph == PH_HTYPE || ph == PH_HSIZE || ph == PH_HPLAT ||
                   ph == PH_HNALG || ph == PH_EPCR || ph == PH_ETYPE || ph == PH_ECNT ||
                   ph == PH_EDSZ) begin
        fd = fld4;
      end
      if (fd) fv = accb;
      unique case (ph)
        PH_HPCR, PH_HTYPE, PH_HSIZE, PH_HPLAT, PH_HNALG, PH_HALGID, PH_HALGSZ,
        PH_EPCR, PH_ETYPE, PH_ECNT, PH_EALG, PH_EDSZ: begin
          if (fd) begin fbc_nxt = 5'd0; acc_nxt = 32'd0; end
          else begin fbc_nxt = {3'b000, 2'(n + 2'd1)}; acc_nxt = accb; end
        end
        default: ;
      endcase
      unique case (ph)
        PH_HPCR: if (fd) begin
          if (accb != 0) err_nxt = ERR_HPCR; else phase_nxt = PH_HTYPE;
        end
        PH_HTYPE: if (fd) begin
          if (accb != 32'd3) err_nxt = ERR_HTYPE; else phase_nxt = PH_HDIG;
        end
        PH_HDIG: begin
          cnt_last = (fbc0 + 5'd1) >= 5'd20;
          if (b != 8'd0) err_nxt = ERR_HDIG;
          else if (cnt_last) begin fbc_nxt = 5'd0; phase_nxt = PH_HSIZE; end
          else fbc_nxt = fbc0 + 5'd1;
        end
        PH_HSIZE: if (fd) phase_nxt = PH_HSIG;
        PH_HSIG: begin
          cnt_last = (fbc0 + 5'd1) >= 5'd16;
          if (b != sig_byte(fbc0[3:0])) err_nxt = ERR_SIG;
          else if (cnt_last) begin fbc_nxt = 5'd0; phase_nxt = PH_HPLAT; end
          else fbc_nxt = fbc0 + 5'd1;
        end
        PH_HPLAT: if (fd) phase_nxt = PH_HVER;
        PH_HVER: begin
          cnt_last = (fbc0 + 5'd1) >= 5'd4;
          if (cnt_last) begin fbc_nxt = 5'd0; phase_nxt = PH_HNALG; end
          else fbc_nxt = fbc0 + 5'd1;
        end
        PH_HNALG: if (fd) begin
          items_nxt = accb;
          phase_nxt = (accb != 0) ? PH_HALGID : PH_HVSIZE;
        end
        PH_HALGID: begin
          role = ROLE_HALG;
          if (fd) begin
            if (ha == 4'd8 && accb != 32'h0 && accb != 32'h1 && accb != 32'h5 &&
                accb != 32'h6 && accb != 32'h7 && accb != 32'h8 && accb != 32'hA)
              err_nxt = ERR_HALG;
            else phase_nxt = PH_HALGSZ;
          end
        end
        PH_HALGSZ: begin
          role = ROLE_HALG;
          if (fd) begin
            items_nxt = items_r - 32'd1;
            phase_nxt = (items_r != 32'd1) ? PH_HALGID : PH_HVSIZE;
          end
        end
        PH_HVSIZE: begin
          role = ROLE_VEND;
          bleft_nxt = 32'(b);
          phase_nxt = (b != 0) ? PH_HVEND : PH_BOUND;
        end
        PH_HVEND: begin
          role = ROLE_VEND;
          bleft_nxt = bleft_r - 32'd1;
          if (bleft_r == 32'd1) phase_nxt = PH_BOUND;
        end
        PH_EPCR: begin
          role = ROLE_PCR;
          if (fd) begin pcr_nxt = accb; phase_nxt = PH_ETYPE; end
        end
        PH_ETYPE: begin
          role = ROLE_TYPE;
          if (fd) begin
            if (tc[5]) err_nxt = ERR_ETYPE;
            else begin type_nxt = tc[4:0]; phase_nxt = PH_ECNT; end
          end
        end
        PH_ECNT: begin
          role = ROLE_DCNT;
          if (fd) begin
            items_nxt = accb;
            phase_nxt = (accb != 0) ? PH_EALG : PH_EDSZ;
          end
        end
        PH_EALG: begin
          role = ROLE_DALG;
          if (fd) begin
            if (ha[3]) err_nxt = ERR_DALG;
            else begin
              alg_nxt = ha[2:0];
              bleft_nxt = 32'(digest_len(ha[2:0]));
              phase_nxt = PH_EDIG;
            end
          end
        end
        PH_EDIG: begin
          role = ROLE_DIG;
          bleft_nxt = bleft_r - 32'd1;
          if (bleft_r == 32'd1) begin
            items_nxt = items_r - 32'd1;
            phase_nxt = (items_r != 32'd1) ? PH_EALG : PH_EDSZ;
          end
        end
        PH_EDSZ: begin
          role = ROLE_DSZ;
          if (fd) begin
            bleft_nxt = accb;
            if (accb == 0) begin evc_nxt = evc0 + 24'd1; phase_nxt = PH_BOUND; end
            else phase_nxt = PH_EDATA;
          end
        end
        PH_EDATA: begin
          role = ROLE_DATA;
          bleft_nxt = bleft_r - 32'd1;
          if (bleft_r == 32'd1) begin evc_nxt = evc0 + 24'd1; phase_nxt = PH_BOUND; end
        end
        default: role = ROLE_TRAIL;
      endcase
      if (done && err_nxt == ERR_NONE && phase_nxt != PH_BOUND && phase_nxt != PH_TRAIL)
        err_nxt = ERR_TRUNC;
    end
    pos_nxt = (pos0 != '1) ? pos0 + 1'b1 : pos0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HPCR; fbc_r <= '0; acc_r <= '0; items_r <= '0; bleft_r <= '0;
      pos_r <= '0; evc_r <= '0; pcr_r <= '0; type_r <= '0; alg_r <= '0; err_r <= ERR_NONE;
    end else if (step) begin
      phase_r <= phase_nxt; fbc_r <= fbc_nxt; acc_r <= acc_nxt; items_r <= items_nxt;
      bleft_r <= bleft_nxt; pos_r <= pos_nxt; evc_r <= evc_nxt; pcr_r <= pcr_nxt;
      type_r <= type_nxt; alg_r <= alg_nxt; err_r <= err_nxt;
    end
  end

  always_comb begin
    res.role = role;
    res.byte_value = b;
    res.event_number = evc0;
    res.pcr_index = pcr_nxt;
    res.event_type_code = type_nxt;
    res.alg_code = alg_nxt;
    res.field_value = fv;
    res.field_done = fd;
    res.selected = (pcr_nxt < 32'd32) ? pcr_mask[pcr_nxt[4:0]] : 1'b0;
    res.error = err_nxt;
    res.log_done = done;
  end

endmodule

// ----- rtl/tcg_event_log_parser.sv -----
// Event log parser. One log byte per beat on in_*, one result beat per byte on out_*.
// in_tdata: data_byte; in_tuser: first_byte (restarts parsing with that byte).
// out_tdata packs role, byte_value, event_number, pcr_index, event_type_code,
// alg_code, field_value, field_done, selected, error, log_done from bit 0 up.
// Configuration: cfg_wr_en with cfg_addr 0 = log_length, 1 = pcr_mask;
// write only while idle.
// A result is held in the output register and appears in the cycle after its byte
// is accepted. Throughput: one byte per cycle while out_tready is high; the parse
// step between the parser state and the output register is combinational.
// When out_tready is low the output register holds and in_tready drops as soon
// as the output register is full and not being drained.
// Reset (rst_n low, synchronous): parser state cleared to the header start,
// log_length 0, pcr_mask all ones, output empty.
module tcg_event_log_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // first_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // role, byte_value, event_number, pcr_index,
                                   // event_type_code, alg_code, field_value,
                                   // field_done, selected, error, log_done
  input  logic         cfg_wr_en,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import tcgp_pkg::*;

  logic [23:0] log_length_r;
  logic [31:0] pcr_mask_r;
  logic        ovalid_r;
  logic [119:0] odata_r;
  result_t     res;
  logic        step;

  assign in_tready = !ovalid_r || out_tready;
  assign step = in_tvalid && in_tready;

  tcgp_core u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .b(in_tdata), .first(in_tuser),
    .log_length(log_length_r), .pcr_mask(pcr_mask_r), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_length_r <= '0;
      pcr_mask_r <= '1;
    end else if (cfg_wr_en) begin
      if (cfg_addr == 1'b0) log_length_r <= cfg_wdata[23:0];
      else pcr_mask_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (in_tready) ovalid_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (step)
      odata_r <= {5'd0, res.log_done, res.error, res.selected, res.field_done,
                  res.field_value, res.alg_code, res.event_type_code, res.pcr_index,
                  res.event_number, res.byte_value, res.role};
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

endmodule

// ----- rtl/tcgp_checker.sv -----
module tcgp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata
);
  a_accept_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid) else $error("accepted beat lost");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("stall while empty");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out dropped");
  a_err_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= 4'd11) else $error("bad role");
endmodule

bind tcg_event_log_parser tcgp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
